// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks with reset masking, used by the top level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GB7_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define GB7_ASSERT_NEVER(lbl, cond, msg) \
    `GB7_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/gb7_pkg.sv =====
// ----------------------------------------------------------------------------
// gb7_pkg
// shared types, kernel weights and constants of the 7x7 gaussian blur
// ----------------------------------------------------------------------------
package gb7_pkg;

    localparam int KDIM         = 7;
    localparam int HIST         = 6;
    localparam int NUM_CH       = 3;
    localparam int PIX_W        = 8;
    localparam int RGB_W        = NUM_CH * PIX_W;
    localparam int HIST_W       = HIST * RGB_W;
    localparam int MIN_SIZE     = 7;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    // row sum, frame sum and reciprocal product widths
    localparam int RSUM_W = 17;
    localparam int TOT_W  = 18;
    localparam int RECIP_W = 19;
    localparam int PROD_W = TOT_W + RECIP_W;
    localparam int QSHIFT = 28;

    // ceil(2^28 / 1003), exact for every sum below 2^18
    localparam logic [RECIP_W-1:0] RECIP = 19'd267633;

    typedef logic [PIX_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_pixel;
    typedef t_pixel [KDIM-1:0] t_row;
    typedef t_row [KDIM-1:0] t_window;
    typedef logic [7:0] t_weight;

    localparam t_weight GAUSS [KDIM][KDIM] = '{
        '{8'd0, 8'd0,  8'd1,  8'd2,   8'd1,  8'd0,  8'd0},
        '{8'd0, 8'd3,  8'd13, 8'd22,  8'd13, 8'd3,  8'd0},
        '{8'd1, 8'd13, 8'd59, 8'd97,  8'd59, 8'd13, 8'd1},
        '{8'd2, 8'd22, 8'd97, 8'd159, 8'd97, 8'd22, 8'd2},
        '{8'd1, 8'd13, 8'd59, 8'd97,  8'd59, 8'd13, 8'd1},
        '{8'd0, 8'd3,  8'd13, 8'd22,  8'd13, 8'd3,  8'd0},
        '{8'd0, 8'd0,  8'd1,  8'd2,   8'd1,  8'd0,  8'd0}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic produce;
        logic last;
    } t_tag;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
        logic  last;
    } t_result;

endpackage

// ===== src/gb7_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gb7_cfg_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
interface gb7_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gb7_pkg::CFG_IDX_W-1:0]     index;
    logic [gb7_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/gb7_pix_if.sv =====
// ----------------------------------------------------------------------------
// gb7_pix_if
// incoming pixel stream with valid/ready
// ----------------------------------------------------------------------------
interface gb7_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gb7_pkg::PIX_W-1:0]   blue_in;
    logic [gb7_pkg::PIX_W-1:0]   green_in;
    logic [gb7_pkg::PIX_W-1:0]   red_in;
    logic                        frame_start;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    output frame_start, input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    input frame_start, output ready);
endinterface

// ===== src/gb7_res_if.sv =====
// ----------------------------------------------------------------------------
// gb7_res_if
// blurred pixel stream with valid/ready
// ----------------------------------------------------------------------------
interface gb7_res_if;
    logic                        valid;
    logic                        ready;
    logic [gb7_pkg::PIX_W-1:0]   blue_out;
    logic [gb7_pkg::PIX_W-1:0]   green_out;
    logic [gb7_pkg::PIX_W-1:0]   red_out;
    logic                        last_of_frame;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output last_of_frame, input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    input last_of_frame, output ready);
endinterface

// ===== src/gb7_ram.sv =====
// ----------------------------------------------------------------------------
// gb7_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gb7_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/gb7_window.sv =====
// ----------------------------------------------------------------------------
// gb7_window
// line store read-modify-write per column and 7x7 window shift register
// ----------------------------------------------------------------------------
module gb7_window #(
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  gb7_pkg::t_tag            i_tag,
    input  logic [$clog2(DEPTH)-1:0] i_col,
    input  gb7_pkg::t_pixel          i_pixel,
    output gb7_pkg::t_window         o_win,
    output gb7_pkg::t_tag            o_tag
);

    localparam int AW = $clog2(DEPTH);
    localparam int KD = gb7_pkg::KDIM;

    gb7_pkg::t_tag                   r_tag1;
    logic [AW-1:0]                   r_col1;
    gb7_pkg::t_pixel                 r_pix1;
    logic                            r_fwd;
    logic [gb7_pkg::HIST_W-1:0]      r_fwd_data;
    logic [gb7_pkg::HIST_W-1:0]      ram_q;
    logic [gb7_pkg::HIST_W-1:0]      hist_q;
    logic [gb7_pkg::HIST_W-1:0]      n_hist;
    logic                            wr_en;
    gb7_pkg::t_window                r_win;
    gb7_pkg::t_tag                   r_tag2;

    assign wr_en = i_en && r_tag1.valid;

    gb7_ram #(
        .WIDTH (gb7_pkg::HIST_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_col1),
        .i_wr_data (n_hist),
        .i_rd_en   (i_en),
        .i_rd_addr (i_col),
        .o_rd_data (ram_q)
    );

    // oldest line in the low entry, newest pixel pushed in at the top
    always_comb begin
        hist_q = r_fwd ? r_fwd_data : ram_q;
        n_hist = {r_pix1, hist_q[gb7_pkg::HIST_W-1:gb7_pkg::RGB_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_fwd  <= 1'b0;
        end else if (i_en) begin
            r_tag1 <= i_tag;
            r_tag2 <= '{valid: r_tag1.valid && r_tag1.produce,
                        produce: r_tag1.produce, last: r_tag1.last};
            // same column written and read at this edge
            r_fwd  <= r_tag1.valid && i_tag.valid && (i_col == r_col1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col1     <= i_col;
            r_pix1     <= i_pixel;
            r_fwd_data <= n_hist;
            if (r_tag1.valid) begin
                for (int r = 0; r < KD; r++) begin
                    for (int c = 0; c < KD - 1; c++) begin
                        r_win[r][c] <= r_win[r][c+1];
                    end
                end
                for (int k = 0; k < gb7_pkg::HIST; k++) begin
                    r_win[k][KD-1] <= hist_q[k*gb7_pkg::RGB_W +: gb7_pkg::RGB_W];
                end
                r_win[KD-1][KD-1] <= r_pix1;
            end
        end
    end

    assign o_win = r_win;
    assign o_tag = r_tag2;

endmodule

// ===== src/gb7_filter.sv =====
// ----------------------------------------------------------------------------
// gb7_filter
// weighted row sums, frame sum and reciprocal divide by 1003
// ----------------------------------------------------------------------------
module gb7_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  gb7_pkg::t_window  i_win,
    input  gb7_pkg::t_tag     i_tag,
    output logic              o_valid,
    output gb7_pkg::t_result  o_res
);

    localparam int KD = gb7_pkg::KDIM;
    localparam int NC = gb7_pkg::NUM_CH;

    logic [gb7_pkg::RSUM_W-1:0] n_rsum [NC][KD];
    logic [gb7_pkg::RSUM_W-1:0] r_rsum [NC][KD];
    logic [gb7_pkg::TOT_W-1:0]  n_tot  [NC];
    logic [gb7_pkg::TOT_W-1:0]  r_tot  [NC];
    logic [gb7_pkg::PROD_W-1:0] r_prod [NC];
    gb7_pkg::t_tag              r_tag_a;
    gb7_pkg::t_tag              r_tag_b;
    gb7_pkg::t_tag              r_tag_c;

    always_comb begin
        logic [gb7_pkg::RSUM_W-1:0] acc;
        acc = '0;
        for (int ch = 0; ch < NC; ch++) begin
            for (int r = 0; r < KD; r++) begin
                acc = '0;
                for (int c = 0; c < KD; c++) begin
                    acc = acc + gb7_pkg::RSUM_W'(i_win[r][c][ch])
                              * gb7_pkg::RSUM_W'(gb7_pkg::GAUSS[r][c]);
                end
                n_rsum[ch][r] = acc;
            end
        end
    end

    always_comb begin
        logic [gb7_pkg::TOT_W-1:0] tot;
        tot = '0;
        for (int ch = 0; ch < NC; ch++) begin
            tot = '0;
            for (int r = 0; r < KD; r++) begin
                tot = tot + gb7_pkg::TOT_W'(r_rsum[ch][r]);
            end
            n_tot[ch] = tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
        end else if (i_en) begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < NC; ch++) begin
                r_rsum[ch] <= n_rsum[ch];
                r_tot[ch]  <= n_tot[ch];
                r_prod[ch] <= gb7_pkg::PROD_W'(r_tot[ch])
                            * gb7_pkg::PROD_W'(gb7_pkg::RECIP);
            end
        end
    end

    assign o_valid     = r_tag_c.valid;
    assign o_res.blue  = r_prod[0][gb7_pkg::QSHIFT +: gb7_pkg::PIX_W];
    assign o_res.green = r_prod[1][gb7_pkg::QSHIFT +: gb7_pkg::PIX_W];
    assign o_res.red   = r_prod[2][gb7_pkg::QSHIFT +: gb7_pkg::PIX_W];
    assign o_res.last  = r_tag_c.last;

endmodule

// ===== src/gaussian_blur_7x7_rgb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_7x7_rgb
// registered in turn: input pixel, window, row sums, frame sum, product, output
// throughput: 1 pixel per cycle, one line store read and one write per cycle
// border pixels give no result; input stalls once output and skid both hold a result
// reset: counters to column 0 row 0, size 640x480, line store left uncleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_blur_7x7_rgb #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gb7_cfg_if.sink       i_cfg,
    gb7_pix_if.sink       i_pix,
    gb7_res_if.source     o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;

    logic [gb7_pkg::WIDTH_REG_W-1:0]  r_image_width;
    logic [gb7_pkg::HEIGHT_REG_W-1:0] r_image_height;
    logic [CW-1:0]                    r_col;
    logic [CW-1:0]                    n_col;
    logic [RW-1:0]                    r_row;
    logic [RW-1:0]                    n_row;
    logic [WW-1:0]                    w_eff;
    logic [HW-1:0]                    h_eff;
    logic [CW-1:0]                    cur_col;
    logic [RW-1:0]                    cur_row;
    logic [WW-1:0]                    col_ext;
    logic [HW-1:0]                    row_ext;
    logic                             in_xfer;
    logic                             en;
    logic                             prod_now;
    logic                             last_now;
    gb7_pkg::t_tag                    in_tag;
    gb7_pkg::t_pixel                  in_pixel;
    gb7_pkg::t_window                 win;
    gb7_pkg::t_tag                    win_tag;
    logic                             flt_valid;
    gb7_pkg::t_result                 flt_res;
    gb7_pkg::t_result                 r_out;
    gb7_pkg::t_result                 n_out;
    logic                             r_out_v;
    logic                             n_out_v;
    gb7_pkg::t_result                 r_skid;
    gb7_pkg::t_result                 n_skid;
    logic                             r_skid_v;
    logic                             n_skid_v;
    logic                             out_take;

    // config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 12'd640;
            r_image_height <= 13'd480;
        end else if (i_cfg.valid) begin
            case (gb7_pkg::t_cfg_reg'(i_cfg.index))
                gb7_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg.data[gb7_pkg::WIDTH_REG_W-1:0];
                end
                gb7_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg.data[gb7_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamped frame size
    always_comb begin
        if (32'(r_image_width) < 32'(gb7_pkg::MIN_SIZE)) begin
            w_eff = WW'(gb7_pkg::MIN_SIZE);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (32'(r_image_height) < 32'(gb7_pkg::MIN_SIZE)) begin
            h_eff = HW'(gb7_pkg::MIN_SIZE);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_image_height);
        end
    end

    // position of the incoming pixel
    assign en          = !r_skid_v;
    assign i_pix.ready = en;
    assign in_xfer     = i_pix.valid && en;

    always_comb begin
        cur_col  = i_pix.frame_start ? '0 : r_col;
        cur_row  = i_pix.frame_start ? '0 : r_row;
        col_ext  = {1'b0, cur_col};
        row_ext  = {1'b0, cur_row};
        prod_now = (cur_col >= CW'(gb7_pkg::KDIM - 1)) && (col_ext < w_eff)
                && (cur_row >= RW'(gb7_pkg::KDIM - 1)) && (row_ext < h_eff);
        last_now = (col_ext == w_eff - WW'(1)) && (row_ext == h_eff - HW'(1));
        n_col    = r_col;
        n_row    = r_row;
        if (in_xfer) begin
            if (col_ext + WW'(1) >= w_eff) begin
                n_col = '0;
                n_row = (row_ext + HW'(1) >= h_eff) ? '0 : cur_row + RW'(1);
            end else begin
                n_col = cur_col + CW'(1);
                n_row = cur_row;
            end
        end
        in_tag      = '{valid: in_xfer, produce: prod_now, last: last_now};
        in_pixel[0] = i_pix.blue_in;
        in_pixel[1] = i_pix.green_in;
        in_pixel[2] = i_pix.red_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    gb7_window #(
        .DEPTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (in_tag),
        .i_col   (cur_col),
        .i_pixel (in_pixel),
        .o_win   (win),
        .o_tag   (win_tag)
    );

    gb7_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_win   (win),
        .i_tag   (win_tag),
        .o_valid (flt_valid),
        .o_res   (flt_res)
    );

    // output register with skid stage
    always_comb begin
        out_take = r_out_v && o_res.ready;
        n_out    = r_out;
        n_out_v  = r_out_v && !out_take;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            if (out_take) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end
        end else if (flt_valid) begin
            if (!r_out_v || out_take) begin
                n_out   = flt_res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = flt_res;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid         = r_out_v;
    assign o_res.blue_out      = r_out.blue;
    assign o_res.green_out     = r_out.green;
    assign o_res.red_out       = r_out.red;
    assign o_res.last_of_frame = r_out.last;

    `GB7_ASSERT_NEVER(a_skid_without_out, r_skid_v && !r_out_v, "skid full, output empty")
    `GB7_ASSERT(a_skid_fill, $rose(r_skid_v) |-> $past(r_out_v && !o_res.ready), "bad skid fill")
    `GB7_ASSERT(a_last_interior, in_xfer && last_now |-> prod_now, "last pixel not interior")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 7x7 gaussian blur: a scoreboard class keeps its
// own line store, window and raster counters, predicts every interior pixel
// and checks the blurred stream transfer by transfer. Directed frames cover
// the reset size, clamped and masked sizes, saturated and impulse images,
// frames with and without a start mark; random frames, some cut short, run
// under sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 4096;
    localparam int WEIGHT_TOTAL  = 1003;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 960;
    localparam int SUB_PHASES    = 2;
    localparam int SUB_ITEMS     = RANDOM_ITEMS / (4 * SUB_PHASES);
    localparam int SHORT_RUN     = 120;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // index codes with no register behind them
    localparam logic [gb7_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [gb7_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int SEND_IDLE_PCT [4] = '{0, 52, 0, 24};
    localparam int STALL_PCT     [4] = '{0, 0, 52, 24};

    localparam int BLUR_KERNEL [gb7_pkg::KDIM][gb7_pkg::KDIM] = '{
        '{0, 0,  1,  2,   1,  0,  0},
        '{0, 3,  13, 22,  13, 3,  0},
        '{1, 13, 59, 97,  59, 13, 1},
        '{2, 22, 97, 159, 97, 22, 2},
        '{1, 13, 59, 97,  59, 13, 1},
        '{0, 3,  13, 22,  13, 3,  0},
        '{0, 0,  1,  2,   1,  0,  0}
    };

    typedef enum int {
        PAT_RANDOM,
        PAT_EXTREME,
        PAT_MAX,
        PAT_ZERO,
        PAT_IMPULSE
    } t_pattern;

    class blur_scoreboard;
        logic [gb7_pkg::WIDTH_REG_W-1:0]  width_reg;
        logic [gb7_pkg::HEIGHT_REG_W-1:0] height_reg;
        gb7_pkg::t_pixel                  line_hist [MAX_W][gb7_pkg::HIST];
        gb7_pkg::t_pixel                  win [gb7_pkg::KDIM][gb7_pkg::KDIM];
        int                               col_cnt;
        int                               row_cnt;
        gb7_pkg::t_result                 expected_blur [$];
        int                               errors;
        int                               results_seen;

        function new();
            width_reg    = 12'd640;
            height_reg   = 13'd480;
            col_cnt      = 0;
            row_cnt      = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int frame_width();
            if (width_reg < gb7_pkg::MIN_SIZE) return gb7_pkg::MIN_SIZE;
            if (width_reg > MAX_W) return MAX_W;
            return int'(width_reg);
        endfunction

        function int frame_height();
            if (height_reg < gb7_pkg::MIN_SIZE) return gb7_pkg::MIN_SIZE;
            if (height_reg > MAX_H) return MAX_H;
            return int'(height_reg);
        endfunction

        function int pending();
            return expected_blur.size();
        endfunction

        function void write_reg(logic [gb7_pkg::CFG_IDX_W-1:0] idx,
                                logic [gb7_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                gb7_pkg::REG_IMAGE_WIDTH: begin
                    width_reg = value[gb7_pkg::WIDTH_REG_W-1:0];
                end
                gb7_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg = value[gb7_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function gb7_pkg::t_chan blur_channel(int ch);
            int acc;
            acc = 0;
            for (int r = 0; r < gb7_pkg::KDIM; r++)
                for (int c = 0; c < gb7_pkg::KDIM; c++)
                    acc += int'(win[r][c][ch]) * BLUR_KERNEL[r][c];
            return gb7_pkg::t_chan'(acc / WEIGHT_TOTAL);
        endfunction

        function void note_pixel(gb7_pkg::t_pixel px, logic fs);
            int               w;
            int               h;
            int               col;
            gb7_pkg::t_result blurred;
            w = frame_width();
            h = frame_height();
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            col = col_cnt % MAX_W;
            for (int r = 0; r < gb7_pkg::KDIM; r++)
                for (int c = 0; c < gb7_pkg::KDIM - 1; c++)
                    win[r][c] = win[r][c + 1];
            for (int k = 0; k < gb7_pkg::HIST; k++)
                win[k][gb7_pkg::KDIM - 1] = line_hist[col][k];
            win[gb7_pkg::KDIM - 1][gb7_pkg::KDIM - 1] = px;
            for (int k = 0; k < gb7_pkg::HIST - 1; k++)
                line_hist[col][k] = line_hist[col][k + 1];
            line_hist[col][gb7_pkg::HIST - 1] = px;
            if (col_cnt >= gb7_pkg::KDIM - 1 && col_cnt < w
                && row_cnt >= gb7_pkg::KDIM - 1 && row_cnt < h) begin
                blurred.blue  = blur_channel(CH_BLUE);
                blurred.green = blur_channel(CH_GREEN);
                blurred.red   = blur_channel(CH_RED);
                blurred.last  = (col_cnt == w - 1 && row_cnt == h - 1);
                expected_blur.push_back(blurred);
            end
            if (col_cnt + 1 >= w) begin
                col_cnt = 0;
                if (row_cnt + 1 >= h) row_cnt = 0;
                else row_cnt++;
            end else begin
                col_cnt++;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("error: result %0d: %s", results_seen, msg);
        endtask

        task check_pixel(gb7_pkg::t_result got);
            gb7_pkg::t_result want;
            results_seen++;
            if (expected_blur.size() == 0) begin
                report_mismatch("blurred pixel with none predicted");
                return;
            end
            want = expected_blur.pop_front();
            if (got.blue != want.blue)
                report_mismatch($sformatf("blue %0d, predicted %0d", got.blue, want.blue));
            if (got.green != want.green)
                report_mismatch($sformatf("green %0d, predicted %0d", got.green, want.green));
            if (got.red != want.red)
                report_mismatch($sformatf("red %0d, predicted %0d", got.red, want.red));
            if (got.last != want.last)
                report_mismatch($sformatf("last_of_frame %0b, predicted %0b",
                                          got.last, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    gb7_cfg_if cfg_bus ();
    gb7_pix_if pix_bus ();
    gb7_res_if res_bus ();

    gaussian_blur_7x7_rgb #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    blur_scoreboard sb;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    bit             hold_req = 1'b0;
    int             cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // observe every transfer on the three channels
    always @(posedge i_clk) begin
        gb7_pkg::t_pixel  px;
        gb7_pkg::t_result got;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
            if (pix_bus.valid && pix_bus.ready) begin
                px[CH_BLUE]  = pix_bus.blue_in;
                px[CH_GREEN] = pix_bus.green_in;
                px[CH_RED]   = pix_bus.red_in;
                sb.note_pixel(px, pix_bus.frame_start);
            end
            if (res_bus.valid && res_bus.ready) begin
                got.blue  = res_bus.blue_out;
                got.green = res_bus.green_out;
                got.red   = res_bus.red_out;
                got.last  = res_bus.last_of_frame;
                sb.check_pixel(got);
            end
        end
    end

    // output side: random stalls, calm stretches and the long hold-off
    initial begin
        int hold_left;
        int calm_left;
        hold_left = 0;
        calm_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                res_bus.ready <= 1'b0;
            end else begin
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(99) < 3) calm_left = $urandom_range(60, 20);
                res_bus.ready <= (calm_left > 0) || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task write_reg(logic [gb7_pkg::CFG_IDX_W-1:0] idx, logic [gb7_pkg::CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    task set_size(logic [gb7_pkg::CFG_DATA_W-1:0] width_data,
                  logic [gb7_pkg::CFG_DATA_W-1:0] height_data);
        write_reg(gb7_pkg::REG_IMAGE_WIDTH, width_data);
        write_reg(gb7_pkg::REG_IMAGE_HEIGHT, height_data);
        cfg_bus.valid <= 1'b0;
    endtask

    task send_pixel(gb7_pkg::t_pixel px, bit fs, bit calm);
        while (!calm && $urandom_range(99) < send_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.blue_in     <= px[CH_BLUE];
        pix_bus.green_in    <= px[CH_GREEN];
        pix_bus.red_in      <= px[CH_RED];
        pix_bus.frame_start <= fs;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
    endtask

    // npix of zero sends the whole frame at the current size
    task send_frame(t_pattern pat, bit fs, int npix);
        int              w;
        int              h;
        int              count;
        bit              calm;
        gb7_pkg::t_pixel px;
        w = sb.frame_width();
        h = sb.frame_height();
        count = (npix > 0) ? npix : w * h;
        calm = ($urandom_range(99) < 20);
        for (int i = 0; i < count; i++) begin
            case (pat)
                PAT_MAX: begin
                    px = '1;
                end
                PAT_ZERO: begin
                    px = '0;
                end
                PAT_IMPULSE: begin
                    px = '0;
                    if (i == 3 * w + 3) begin
                        px[CH_BLUE]  = 8'd255;
                        px[CH_GREEN] = 8'd128;
                        px[CH_RED]   = 8'd1;
                    end
                end
                PAT_EXTREME: begin
                    for (int ch = 0; ch < gb7_pkg::NUM_CH; ch++)
                        px[ch] = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: begin
                    for (int ch = 0; ch < gb7_pkg::NUM_CH; ch++)
                        if ($urandom_range(99) < 15) px[ch] = $urandom_range(1) ? 8'd255 : 8'd0;
                        else px[ch] = gb7_pkg::t_chan'($urandom_range(255));
                end
            endcase
            send_pixel(px, fs && i == 0, calm);
        end
    endtask

    task settle();
        pix_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                             sent;
        int                             count;
        int                             roll;
        bit                             prev_done;
        t_pattern                       pat;
        logic [gb7_pkg::CFG_DATA_W-1:0] width_data;
        logic [gb7_pkg::CFG_DATA_W-1:0] height_data;
        sb = new();
        pix_bus.valid       <= 1'b0;
        pix_bus.blue_in     <= '0;
        pix_bus.green_in    <= '0;
        pix_bus.red_in      <= '0;
        pix_bus.frame_start <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= gb7_pkg::REG_IMAGE_WIDTH;
        cfg_bus.data        <= '0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: a short run, then the frame is abandoned
        send_frame(PAT_RANDOM, 1'b1, SHORT_RUN);
        settle();

        // sizes below the minimum, unmapped indexes, smallest frames
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, gb7_pkg::CFG_DATA_W'($urandom_range(8191)));
        set_size(13'd3, 13'd0);
        send_frame(PAT_MAX, 1'b1, 0);
        send_frame(PAT_ZERO, 1'b0, 0);
        send_frame(PAT_IMPULSE, 1'b1, 0);
        send_frame(PAT_EXTREME, 1'b0, 0);
        settle();

        // widest line, masked and clamped, start of a frame only
        set_size(13'h1FFF, 13'd7);
        send_frame(PAT_RANDOM, 1'b1, SHORT_RUN);
        settle();

        // tallest frame, clamped, first lines only
        set_size(13'd0, 13'h1FFF);
        send_frame(PAT_RANDOM, 1'b1, sb.frame_width() * 2 * gb7_pkg::KDIM);
        settle();

        // output held off while input keeps coming
        set_size(13'd40, 13'd10);
        hold_req = 1'b1;
        send_frame(PAT_RANDOM, 1'b1, 0);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = SEND_IDLE_PCT[phase];
            stall_pct     = STALL_PCT[phase];
            for (int sub = 0; sub < SUB_PHASES; sub++) begin
                settle();
                roll = $urandom_range(99);
                if (roll < 15) width_data = gb7_pkg::CFG_DATA_W'($urandom_range(6));
                else if (roll < 25) width_data = gb7_pkg::CFG_DATA_W'($urandom_range(70, 25));
                else width_data = gb7_pkg::CFG_DATA_W'($urandom_range(24, 7));
                width_data[gb7_pkg::WIDTH_REG_W] = $urandom_range(1);
                if ($urandom_range(99) < 15)
                    height_data = gb7_pkg::CFG_DATA_W'($urandom_range(6));
                else
                    height_data = gb7_pkg::CFG_DATA_W'($urandom_range(12, 7));
                set_size(width_data, height_data);

                sent = 0;
                prev_done = 1'b0;
                while (sent < SUB_ITEMS) begin
                    count = sb.frame_width() * sb.frame_height();
                    roll = $urandom_range(99);
                    if (roll < 12) count = $urandom_range(count - 1, 1);
                    if (count > SUB_ITEMS - sent) count = SUB_ITEMS - sent;
                    pat = ($urandom_range(99) < 15) ? PAT_EXTREME : PAT_RANDOM;
                    send_frame(pat, !(prev_done && roll >= 12 && roll < 30), count);
                    prev_done = (count == sb.frame_width() * sb.frame_height());
                    sent += count;
                end
            end
        end
        settle();

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
